### hdl/pgsu_pkg.sv
// shared constants and types for the pid steering unit with stop gate
package pgsu_pkg;

  // field widths
  localparam int POS_W      = 16;
  localparam int ERR_W      = 17;
  localparam int INTEG_W    = 18;
  localparam int GAIN_W     = 16;
  localparam int ILIM_W     = 17;
  localparam int OLIM_W     = 15;
  localparam int SPEED_W    = 15;
  localparam int RATE_W     = 16;

  // stream and config port widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  // control loop rate in ticks per second
  localparam int LOOP_RATE_HZ_DEF = 30;

  // register reset values
  localparam logic [POS_W-1:0]   SETPOINT_RST = 16'd32768;
  localparam logic [GAIN_W-1:0]  KP_RST       = 16'd3277;
  localparam logic [GAIN_W-1:0]  KI_RST       = 16'd0;
  localparam logic [GAIN_W-1:0]  KD_RST       = 16'd0;
  localparam logic [ILIM_W-1:0]  ILIM_RST     = 17'd51472;
  localparam logic [OLIM_W-1:0]  OLIM_RST     = 15'd12868;
  localparam logic [SPEED_W-1:0] CRUISE_RST   = 15'd614;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT       = 3'd0,
    CFG_KP_GAIN        = 3'd1,
    CFG_KI_GAIN        = 3'd2,
    CFG_KD_GAIN        = 3'd3,
    CFG_INTEGRAL_LIMIT = 3'd4,
    CFG_OUTPUT_LIMIT   = 3'd5,
    CFG_CRUISE_SPEED   = 3'd6
  } cfg_idx_e;

endpackage

### hdl/pid_steering_with_stop_gate_unit.sv
// top level of the pid steering unit with stop gate
//
// usage
//   s_axis carries one control tick per beat: tdata holds the measured target
//   position (q0.16 of image width), tuser holds the object-detected flag.
//   m_axis returns one beat per tick: linear speed and angular rate (q3.12),
//   both forced to zero when the tick flags a detected object.
//   the cfg port writes one register per cycle while cfg_we_i is high;
//   index 0..6 is setpoint, kp, ki, kd, integral limit, output limit,
//   cruise speed, and index 7 is dropped. write only while the unit is idle.
// timing
//   four register stages: input, error/integral update, gain products,
//   sum/shift/clamp into the output register. the result beat passes the
//   input, error/integral and gain-product registers before m_axis_tvalid_o
//   rises; throughput is one tick per cycle while the receiver does not stall. the recurrence
//   on previous error and integral closes inside the error/integral stage.
// reset and stall
//   reset clears all stage valids, the pid state and loads register defaults.
//   each stage holds while the one after it is full and stalled, so a stalled
//   receiver fills the pipe and then drops s_axis_tready_o; bubbles collapse.
module pid_steering_with_stop_gate_unit
  import pgsu_pkg::*;
#(
  parameter int LOOP_RATE_HZ = LOOP_RATE_HZ_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [15:0] position
  input  logic                   s_axis_tuser_i,   // [0] object_detected
  // output stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [14:0] linear_speed, [30:15] angular_rate
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  // trapezoid divide by 2*rate: exact floor via rounded-up reciprocal
  localparam int     MAG_W   = ERR_W;                    // magnitude of error sum
  localparam int     Q_W     = 16;                       // quotient, at most 65535
  localparam int     DIV_D   = 2 * LOOP_RATE_HZ;
  localparam int     DIV_L   = $clog2(DIV_D);
  localparam int     DIV_S   = MAG_W + DIV_L;
  localparam longint DIV_M   = ((longint'(1) << DIV_S) + longint'(DIV_D) - 1) / DIV_D;
  localparam int     M_W     = MAG_W + 2;
  localparam int     PRD_W   = MAG_W + M_W;

  // derivative and product widths
  localparam int     DERIV_W = INTEG_W + $clog2(LOOP_RATE_HZ + 1);
  localparam int     PP_W    = GAIN_W + 1 + ERR_W;
  localparam int     IP_W    = GAIN_W + 1 + INTEG_W;
  localparam int     DP_W    = GAIN_W + 1 + DERIV_W;
  localparam int     ACC_W   = DP_W + 2;
  localparam int     FRAC_SH = 16;                       // q.28 -> q3.12

  localparam logic [M_W-1:0]             DIV_M_C  = M_W'(DIV_M);
  localparam logic signed [DERIV_W-1:0]  RATE_C   = DERIV_W'(LOOP_RATE_HZ);

  // configuration registers
  logic [POS_W-1:0]   setpoint_q;
  logic [GAIN_W-1:0]  kp_q, ki_q, kd_q;
  logic [ILIM_W-1:0]  ilim_q;
  logic [OLIM_W-1:0]  olim_q;
  logic [SPEED_W-1:0] cruise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SETPOINT_RST;
      kp_q       <= KP_RST;
      ki_q       <= KI_RST;
      kd_q       <= KD_RST;
      ilim_q     <= ILIM_RST;
      olim_q     <= OLIM_RST;
      cruise_q   <= CRUISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SETPOINT:       setpoint_q <= cfg_wdata_i[POS_W-1:0];
        CFG_KP_GAIN:        kp_q       <= cfg_wdata_i[GAIN_W-1:0];
        CFG_KI_GAIN:        ki_q       <= cfg_wdata_i[GAIN_W-1:0];
        CFG_KD_GAIN:        kd_q       <= cfg_wdata_i[GAIN_W-1:0];
        CFG_INTEGRAL_LIMIT: ilim_q     <= cfg_wdata_i[ILIM_W-1:0];
        CFG_OUTPUT_LIMIT:   olim_q     <= cfg_wdata_i[OLIM_W-1:0];
        CFG_CRUISE_SPEED:   cruise_q   <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage moves on when the next one is empty or moving
  logic in_v_q, s1_v_q, s2_v_q, out_v_q;
  logic out_free, s2_free, s1_free, in_free;
  logic adv_out, adv_s2, adv_s1, in_acc;

  assign out_free = !out_v_q || m_axis_tready_i;
  assign s2_free  = !s2_v_q  || out_free;
  assign s1_free  = !s1_v_q  || s2_free;
  assign in_free  = !in_v_q  || s1_free;

  assign adv_out  = s2_v_q && out_free;
  assign adv_s2   = s1_v_q && s2_free;
  assign adv_s1   = in_v_q && s1_free;
  assign in_acc   = s_axis_tvalid_i && in_free;

  assign s_axis_tready_o = in_free;
  assign m_axis_tvalid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_acc  || (in_v_q  && !s1_free);
      s1_v_q  <= adv_s1  || (s1_v_q  && !s2_free);
      s2_v_q  <= adv_s2  || (s2_v_q  && !out_free);
      out_v_q <= adv_out || (out_v_q && !m_axis_tready_i);
    end
  end

  // input register
  logic [POS_W-1:0] pos_q;
  logic             det_in_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q    <= s_axis_tdata_i[POS_W-1:0];
      det_in_q <= s_axis_tuser_i;
    end
  end

  // error, trapezoid integral and derivative; pid state closes here
  logic signed [ERR_W-1:0]   prev_err_q;
  logic signed [INTEG_W-1:0] integ_q;

  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W-1:0] tsum;
  logic [MAG_W-1:0]          tmag;
  logic [PRD_W-1:0]          tprod;
  logic [Q_W-1:0]            quot;
  logic signed [INTEG_W-1:0] delta;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W:0]   ilim_x;
  logic signed [INTEG_W-1:0] integ_d;
  logic signed [INTEG_W-1:0] diff;
  logic signed [DERIV_W-1:0] diff_x;
  logic signed [DERIV_W-1:0] deriv;

  always_comb begin
    err    = $signed({1'b0, setpoint_q}) - $signed({1'b0, pos_q});
    tsum   = INTEG_W'(err) + INTEG_W'(prev_err_q);
    tmag   = tsum[INTEG_W-1] ? MAG_W'(-tsum) : MAG_W'(tsum);
    tprod  = PRD_W'(tmag) * PRD_W'(DIV_M_C);
    quot   = Q_W'(tprod >> DIV_S);
    // truncate toward zero: divide the magnitude, then restore the sign
    delta  = tsum[INTEG_W-1] ? -$signed(INTEG_W'(quot)) : $signed(INTEG_W'(quot));
    isum   = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(delta);
    ilim_x = $signed({2'b00, ilim_q});
    if (isum > ilim_x) begin
      integ_d = INTEG_W'(ilim_x);
    end else if (isum < -ilim_x) begin
      integ_d = INTEG_W'(-ilim_x);
    end else begin
      integ_d = INTEG_W'(isum);
    end
    diff   = INTEG_W'(err) - INTEG_W'(prev_err_q);
    diff_x = DERIV_W'(diff);
    deriv  = diff_x * RATE_C;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
    end else if (adv_s1) begin
      prev_err_q <= err;
      integ_q    <= integ_d;
    end
  end

  logic signed [ERR_W-1:0]   err_s1_q;
  logic signed [INTEG_W-1:0] integ_s1_q;
  logic signed [DERIV_W-1:0] deriv_s1_q;
  logic                      det_s1_q;

  always_ff @(posedge clk_i) begin
    if (adv_s1) begin
      err_s1_q   <= err;
      integ_s1_q <= integ_d;
      deriv_s1_q <= deriv;
      det_s1_q   <= det_in_q;
    end
  end

  // gain products, one multiplier per term
  logic signed [PP_W-1:0] pp;
  logic signed [IP_W-1:0] ip;
  logic signed [DP_W-1:0] dp;

  assign pp = PP_W'($signed({1'b0, kp_q})) * PP_W'(err_s1_q);
  assign ip = IP_W'($signed({1'b0, ki_q})) * IP_W'(integ_s1_q);
  assign dp = DP_W'($signed({1'b0, kd_q})) * DP_W'(deriv_s1_q);

  logic signed [PP_W-1:0] pp_q;
  logic signed [IP_W-1:0] ip_q;
  logic signed [DP_W-1:0] dp_q;
  logic                   det_s2_q;

  always_ff @(posedge clk_i) begin
    if (adv_s2) begin
      pp_q     <= pp;
      ip_q     <= ip;
      dp_q     <= dp;
      det_s2_q <= det_s1_q;
    end
  end

  // sum, floor shift to q3.12, clamp and stop gate
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [ACC_W-1:0]  olim_x;
  logic signed [RATE_W-1:0] rate;
  logic [SPEED_W-1:0]       lin_d;
  logic [RATE_W-1:0]        ang_d;

  always_comb begin
    acc    = ACC_W'(pp_q) + ACC_W'(ip_q) + ACC_W'(dp_q);
    acc_sh = acc >>> FRAC_SH;
    olim_x = $signed(ACC_W'(olim_q));
    if (acc_sh > olim_x) begin
      rate = RATE_W'(olim_x);
    end else if (acc_sh < -olim_x) begin
      rate = RATE_W'(-olim_x);
    end else begin
      rate = RATE_W'(acc_sh);
    end
    lin_d = det_s2_q ? '0 : cruise_q;
    ang_d = det_s2_q ? '0 : rate;
  end

  logic [SPEED_W-1:0] lin_q;
  logic [RATE_W-1:0]  ang_q;

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      lin_q <= lin_d;
      ang_q <= ang_d;
    end
  end

  assign m_axis_tdata_o = {(OUT_TDATA_W-SPEED_W-RATE_W)'(0), ang_q, lin_q};

endmodule

### bench/pid_steering_with_stop_gate_unit_tb.sv
// self-checking bench for the pid steering unit: stream driver, result monitor, steering predictor
`timescale 1ns / 100ps

module pid_steering_with_stop_gate_unit_tb
  import pgsu_pkg::*;
();

  // index beyond the register map, the unit must drop the write
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             detected;
  } tick_t;

  typedef struct packed {
    logic [SPEED_W-1:0]       speed;
    logic signed [RATE_W-1:0] rate;
  } drive_cmd_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  // predictor copy of the register file and the pid state
  logic [POS_W-1:0]          sp_q = SETPOINT_RST;
  logic [GAIN_W-1:0]         kp_q = KP_RST;
  logic [GAIN_W-1:0]         ki_q = KI_RST;
  logic [GAIN_W-1:0]         kd_q = KD_RST;
  logic [ILIM_W-1:0]         ilim_q = ILIM_RST;
  logic [OLIM_W-1:0]         olim_q = OLIM_RST;
  logic [SPEED_W-1:0]        cruise_q = CRUISE_RST;
  logic signed [ERR_W-1:0]   prev_err_q = '0;
  logic signed [INTEG_W-1:0] integ_q = '0;

  tick_t      tick_pending_q[$];
  drive_cmd_t cmd_expected_q[$];
  tick_t      next_tick;
  drive_cmd_t want_cmd;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_ticks = 0;
  int unsigned n_detected = 0;
  int unsigned n_results = 0;
  int unsigned n_writes = 0;
  int unsigned n_mismatch = 0;

  pid_steering_with_stop_gate_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one control tick: error, trapezoid integral, derivative, gain sum, stop gate
  function automatic drive_cmd_t steer_predict(logic [POS_W-1:0] pos, logic detected);
    longint     err;
    longint     sum;
    longint     der;
    longint     acc;
    longint     rate;
    drive_cmd_t cmd;
    err = longint'(sp_q) - longint'(pos);
    // signed division truncates toward zero
    sum = longint'(integ_q) + (err + longint'(prev_err_q)) / (2 * LOOP_RATE_HZ_DEF);
    sum = clamp_sym(sum, longint'(ilim_q));
    der = (err - longint'(prev_err_q)) * LOOP_RATE_HZ_DEF;
    acc = longint'(kp_q) * err + longint'(ki_q) * sum + longint'(kd_q) * der;
    // arithmetic shift floors negative sums
    rate = clamp_sym(acc >>> 16, longint'(olim_q));
    // state advances even on a detected tick
    prev_err_q = err[ERR_W-1:0];
    integ_q = sum[INTEG_W-1:0];
    if (detected) begin
      cmd.speed = '0;
      cmd.rate = '0;
    end else begin
      cmd.speed = cruise_q;
      cmd.rate = rate[RATE_W-1:0];
    end
    return cmd;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_mismatch++;
    $display("bad result %0d at %0t: %s got %0d want %0d", n_results, $realtime, what, got,
             want);
  endtask

  // driver: predict on every accepted beat, then offer the next pending tick
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        cmd_expected_q.push_back(steer_predict(s_axis_tdata_i, s_axis_tuser_i));
        n_ticks++;
        if (s_axis_tuser_i) n_detected++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tick_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_tick = tick_pending_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= next_tick.pos;
          s_axis_tuser_i <= next_tick.detected;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest predicted command
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (cmd_expected_q.size() == 0) begin
          report_mismatch("beat with nothing pending", longint'(m_axis_tdata_o), 0);
        end else begin
          want_cmd = cmd_expected_q.pop_front();
          if (m_axis_tdata_o[14:0] !== want_cmd.speed)
            report_mismatch("linear_speed", longint'(m_axis_tdata_o[14:0]),
                            longint'(want_cmd.speed));
          if (m_axis_tdata_o[30:15] !== want_cmd.rate)
            report_mismatch("angular_rate", longint'($signed(m_axis_tdata_o[30:15])),
                            longint'(want_cmd.rate));
          if (m_axis_tdata_o[31] !== 1'b0)
            report_mismatch("pad bit", longint'(m_axis_tdata_o[31]), 0);
        end
        n_results++;
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // register write, only called while nothing is in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_SETPOINT:       sp_q = val[POS_W-1:0];
      CFG_KP_GAIN:        kp_q = val[GAIN_W-1:0];
      CFG_KI_GAIN:        ki_q = val[GAIN_W-1:0];
      CFG_KD_GAIN:        kd_q = val[GAIN_W-1:0];
      CFG_INTEGRAL_LIMIT: ilim_q = val[ILIM_W-1:0];
      CFG_OUTPUT_LIMIT:   olim_q = val[OLIM_W-1:0];
      CFG_CRUISE_SPEED:   cruise_q = val[SPEED_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_pending_q.size() != 0 || s_axis_tvalid_i || cmd_expected_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic queue_tick(logic [POS_W-1:0] pos, logic detected);
    tick_t t;
    t.pos = pos;
    t.detected = detected;
    tick_pending_q.push_back(t);
  endtask

  // extremes, small values and random values within the width, sometimes wider than the register
  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(int unsigned w);
    logic [CFG_DATA_W-1:0] full;
    full = (CFG_DATA_W'(1) << w) - 1'b1;
    case ($urandom_range(9))
      0: return '0;
      1: return full;
      2: return CFG_DATA_W'($urandom);
      3, 4, 5: return CFG_DATA_W'($urandom_range(1023));
      default: return CFG_DATA_W'($urandom) & full;
    endcase
  endfunction

  task automatic randomize_config();
    write_reg(CFG_SETPOINT, pick_reg_value(POS_W));
    write_reg(CFG_KP_GAIN, pick_reg_value(GAIN_W));
    write_reg(CFG_KI_GAIN, pick_reg_value(GAIN_W));
    write_reg(CFG_KD_GAIN, pick_reg_value(GAIN_W));
    write_reg(CFG_INTEGRAL_LIMIT, pick_reg_value(ILIM_W));
    write_reg(CFG_OUTPUT_LIMIT, pick_reg_value(OLIM_W));
    write_reg(CFG_CRUISE_SPEED, pick_reg_value(SPEED_W));
  endtask

  // tracking sweeps with slowly moving target, plus jumps, extremes and near-setpoint noise
  task automatic queue_random_ticks(int unsigned count);
    int unsigned run_len;
    logic [POS_W-1:0] p;
    int step;
    bit sweep;
    bit hold_det;
    while (count > 0) begin
      sweep = ($urandom_range(99) < 65);
      run_len = $urandom_range(16, 3);
      p = POS_W'($urandom);
      step = int'($urandom_range(2048)) - 1024;
      hold_det = ($urandom_range(99) < 15);
      for (int i = 0; i < run_len && count > 0; i++) begin
        if (sweep) begin
          p = p + POS_W'(step);
        end else begin
          case ($urandom_range(4))
            0: p = '0;
            1: p = '1;
            2: p = sp_q + POS_W'($urandom_range(8)) - POS_W'(4);
            default: p = POS_W'($urandom);
          endcase
        end
        queue_tick(p, hold_det | ($urandom_range(99) < 20));
        count--;
      end
    end
  endtask

  // half the ticks, a full drain with the sender held off, then the rest
  task automatic run_random_phase(int unsigned count);
    queue_random_ticks(count / 2);
    wait_drained();
    queue_random_ticks(count - count / 2);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: both position extremes, setpoint, detected ticks in between
    send_idle_pct = 34;
    recv_idle_pct = 69;
    queue_tick(16'd0, 1'b0);
    queue_tick(16'hffff, 1'b0);
    queue_tick(16'd32768, 1'b1);
    queue_tick(16'd0, 1'b1);
    queue_tick(16'd1, 1'b0);
    queue_tick(16'd32769, 1'b0);
    wait_drained();

    // every register at its top, setpoint, output limit and cruise speed written wider than their width
    write_reg(CFG_SETPOINT, 17'h1ffff);
    write_reg(CFG_KP_GAIN, 17'h0ffff);
    write_reg(CFG_KI_GAIN, 17'h0ffff);
    write_reg(CFG_KD_GAIN, 17'h0ffff);
    write_reg(CFG_INTEGRAL_LIMIT, 17'h1ffff);
    write_reg(CFG_OUTPUT_LIMIT, 17'h1ffff);
    write_reg(CFG_CRUISE_SPEED, 17'h1ffff);
    queue_tick(16'd0, 1'b0);
    queue_tick(16'hffff, 1'b0);
    queue_tick(16'd0, 1'b0);
    queue_tick(16'hffff, 1'b1);
    queue_tick(16'hffff, 1'b0);
    queue_tick(16'h8000, 1'b0);
    wait_drained();

    // zero limits hold integral and rate at zero; spare index must be ignored
    write_reg(CFG_INTEGRAL_LIMIT, 17'd0);
    write_reg(CFG_OUTPUT_LIMIT, 17'd0);
    write_reg(CFG_CRUISE_SPEED, 17'd0);
    write_reg(CFG_SETPOINT, 17'd0);
    write_reg(CFG_IDX_SPARE, 17'h1abcd);
    queue_tick(16'hffff, 1'b0);
    queue_tick(16'd0, 1'b0);
    queue_tick(16'h1234, 1'b1);
    queue_tick(16'hfedc, 1'b0);
    wait_drained();

    // small gains so the clamps do not hide negative floor rounding
    write_reg(CFG_SETPOINT, 17'd32768);
    write_reg(CFG_KP_GAIN, 17'd3);
    write_reg(CFG_KI_GAIN, 17'd4096);
    write_reg(CFG_KD_GAIN, 17'd1);
    write_reg(CFG_INTEGRAL_LIMIT, 17'd51472);
    write_reg(CFG_OUTPUT_LIMIT, 17'd32767);
    write_reg(CFG_CRUISE_SPEED, 17'd614);
    queue_tick(16'd32769, 1'b0);
    queue_tick(16'd32775, 1'b0);
    queue_tick(16'd32760, 1'b0);
    queue_tick(16'd40000, 1'b0);
    wait_drained();

    // random part: receiver sparse first, then sender sparse, then full rate
    run_random_phase(130);
    randomize_config();
    send_idle_pct = 69;
    recv_idle_pct = 34;
    run_random_phase(130);
    randomize_config();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(140);

    // catch stray beats after the pipe should be empty
    repeat (12) @(posedge clk_i);

    $display("ran %0d ticks (%0d with object detected), %0d results, %0d register writes",
             n_ticks, n_detected, n_results, n_writes);
    $display("covered reset defaults, register extremes, zero limits and three idle mixes");
    if (n_mismatch == 0 && cmd_expected_q.size() == 0) begin
      $display("pid_steering_with_stop_gate_unit: match");
    end else begin
      $display("pid_steering_with_stop_gate_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("pid_steering_with_stop_gate_unit: mismatch");
    $finish;
  end

endmodule

### pid_steering_with_stop_gate_unit.f
hdl/pgsu_pkg.sv
hdl/pid_steering_with_stop_gate_unit.sv
bench/pid_steering_with_stop_gate_unit_tb.sv
